FILE: rtl/primary_trigger_selector_macros.svh
// Assertion macros used by the checker file.
// Both assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef PRIMARY_TRIGGER_SELECTOR_MACROS_SVH
`define PRIMARY_TRIGGER_SELECTOR_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("primary trigger selector check failed");

// Consequence must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("primary trigger selector check failed");

`endif

FILE: rtl/ptsel_pkg.sv
`default_nettype none

package ptsel_pkg;

  // Widths fixed by the candidate and result formats.
  localparam int TYPE_W   = 5;
  localparam int TIME_W   = 31;
  localparam int BITS_W   = 32;
  localparam int WIN_W    = 16;
  localparam int PIDX_W   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK      = 3'd0,
    REG_CODE_LOW_ENERGY  = 3'd1,
    REG_CODE_HIGH_ENERGY = 3'd2,
    REG_CODE_SUPER_LOW   = 3'd3,
    REG_CODE_SUPER_HIGH  = 3'd4,
    REG_CODE_OUTER       = 3'd5,
    REG_NEAR_WINDOW      = 3'd6,
    REG_GATE_WINDOW      = 3'd7
  } ptsel_reg_t;

  // Reset values of the configuration registers.
  localparam logic [BITS_W-1:0] RST_ENABLE_MASK      = 32'hFFFF_FFFF;
  localparam logic [TYPE_W-1:0] RST_CODE_LOW_ENERGY  = 5'd0;
  localparam logic [TYPE_W-1:0] RST_CODE_HIGH_ENERGY = 5'd1;
  localparam logic [TYPE_W-1:0] RST_CODE_SUPER_LOW   = 5'd2;
  localparam logic [TYPE_W-1:0] RST_CODE_SUPER_HIGH  = 5'd28;
  localparam logic [TYPE_W-1:0] RST_CODE_OUTER       = 5'd3;
  localparam logic [WIN_W-1:0]  RST_NEAR_WINDOW      = 16'd384;
  localparam logic [WIN_W-1:0]  RST_GATE_WINDOW      = 16'd768;

  // Current configuration as seen by the selection engine.
  typedef struct packed {
    logic [BITS_W-1:0] enable_mask;
    logic [TYPE_W-1:0] code_low_energy;
    logic [TYPE_W-1:0] code_high_energy;
    logic [TYPE_W-1:0] code_super_low;
    logic [TYPE_W-1:0] code_super_high;
    logic [TYPE_W-1:0] code_outer;
    logic [WIN_W-1:0]  near_window;
    logic [WIN_W-1:0]  gate_window;
  } ptsel_cfg_t;

  // Engine sequencing.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK1,
    ST_WALK2,
    ST_DONE
  } ptsel_state_t;

  // One-hot bit of a type code.
  function automatic logic [BITS_W-1:0] type_bit(input logic [TYPE_W-1:0] t);
    type_bit = {{(BITS_W-1){1'b0}}, 1'b1} << t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ptsel_ram.sv
`default_nettype none

module ptsel_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/ptsel_cfg.sv
`default_nettype none

module ptsel_cfg import ptsel_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output ptsel_cfg_t                 cfg_o
);

  ptsel_cfg_t cfg_r;

  // Writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // Register file with decoded write index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask      <= RST_ENABLE_MASK;
      cfg_r.code_low_energy  <= RST_CODE_LOW_ENERGY;
      cfg_r.code_high_energy <= RST_CODE_HIGH_ENERGY;
      cfg_r.code_super_low   <= RST_CODE_SUPER_LOW;
      cfg_r.code_super_high  <= RST_CODE_SUPER_HIGH;
      cfg_r.code_outer       <= RST_CODE_OUTER;
      cfg_r.near_window      <= RST_NEAR_WINDOW;
      cfg_r.gate_window      <= RST_GATE_WINDOW;
    end else if (cfg_valid) begin
      unique case (ptsel_reg_t'(cfg_index))
        REG_ENABLE_MASK:      cfg_r.enable_mask      <= cfg_data;
        REG_CODE_LOW_ENERGY:  cfg_r.code_low_energy  <= cfg_data[TYPE_W-1:0];
        REG_CODE_HIGH_ENERGY: cfg_r.code_high_energy <= cfg_data[TYPE_W-1:0];
        REG_CODE_SUPER_LOW:   cfg_r.code_super_low   <= cfg_data[TYPE_W-1:0];
        REG_CODE_SUPER_HIGH:  cfg_r.code_super_high  <= cfg_data[TYPE_W-1:0];
        REG_CODE_OUTER:       cfg_r.code_outer       <= cfg_data[TYPE_W-1:0];
        REG_NEAR_WINDOW:      cfg_r.near_window      <= cfg_data[WIN_W-1:0];
        REG_GATE_WINDOW:      cfg_r.gate_window      <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ptsel_engine.sv
`default_nettype none

module ptsel_engine import ptsel_pkg::*; #(
  parameter int MAX_CANDIDATES = 64,
  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
  localparam int CW = $clog2(MAX_CANDIDATES + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ptsel_cfg_t               cfg_i,
  // Candidate requests
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [TYPE_W-1:0]        in_trig_type,
  input  wire logic [TIME_W-1:0]        in_trig_time,
  input  wire logic                     in_is_last,
  // Candidate memory
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [TYPE_W+TIME_W-1:0]      ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  wire logic [TYPE_W+TIME_W-1:0] ram_rdata,
  // Result requests
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_found,
  output logic [PIDX_W-1:0]             out_primary_index,
  output logic [TIME_W-1:0]             out_primary_time,
  output logic [BITS_W-1:0]             out_type_bits
);

  ptsel_state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r;      // candidates stored in this list
  logic [CW-1:0]     rd_idx_r;   // next entry to read in a walk
  logic              pv_r;       // read data valid this cycle
  logic [AW-1:0]     pidx_r;     // entry that the read data belongs to

  // Earliest main-class candidate, later merged into the primary.
  logic              m_found_r;
  logic [AW-1:0]     prim_r;
  logic [TIME_W-1:0] t0_r;
  logic [TYPE_W-1:0] ptype_r;
  // First enabled super-low candidate, used only when no main class exists.
  logic              s_found_r;
  logic [AW-1:0]     s_idx_r;
  logic [TIME_W-1:0] s_time_r;
  logic [TYPE_W-1:0] s_type_r;

  logic [BITS_W-1:0] bits_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [PIDX_W-1:0] out_pidx_r;
  logic [TIME_W-1:0] out_time_r;
  logic [BITS_W-1:0] out_bits_r;

  logic              in_acc;
  logic              store_ok;
  logic              walking;
  logic              issue;
  logic              walk_end;
  logic              out_free;
  logic [TYPE_W-1:0] rd_type;
  logic [TIME_W-1:0] rd_time;
  logic              main_hit;
  logic              sl_hit;
  logic [TIME_W-1:0] time_gap;
  logic              near_ok;
  logic              gate_ok;
  logic [AW+PIDX_W-1:0] prim_ext;

  // Walk control and read data split.
  assign in_acc   = in_valid && in_ready;
  assign store_ok = cnt_r < CW'(MAX_CANDIDATES);
  assign walking  = (state_r == ST_WALK1) || (state_r == ST_WALK2);
  assign issue    = walking && (rd_idx_r < cnt_r);
  assign walk_end = walking && (rd_idx_r == cnt_r) && !pv_r;
  assign out_free = !out_valid_r || out_ready;
  assign rd_type  = ram_rdata[TYPE_W+TIME_W-1:TIME_W];
  assign rd_time  = ram_rdata[TIME_W-1:0];

  // Class decode of the entry just read.
  always_comb begin
    main_hit = ((rd_type == cfg_i.code_low_energy) &&
                cfg_i.enable_mask[cfg_i.code_low_energy]) ||
               ((rd_type == cfg_i.code_high_energy) &&
                cfg_i.enable_mask[cfg_i.code_high_energy]) ||
               ((rd_type == cfg_i.code_super_high) &&
                cfg_i.enable_mask[cfg_i.code_super_high]) ||
               ((rd_type == cfg_i.code_outer) &&
                cfg_i.enable_mask[cfg_i.code_outer]);
    sl_hit   = (rd_type == cfg_i.code_super_low) &&
               cfg_i.enable_mask[cfg_i.code_super_low];
  end

  // Distance from the primary's time and the two window tests.
  assign time_gap = (rd_time > t0_r) ? (rd_time - t0_r) : (t0_r - rd_time);
  assign near_ok  = time_gap < {{(TIME_W-WIN_W){1'b0}}, cfg_i.near_window};
  assign gate_ok  = time_gap < {{(TIME_W-WIN_W){1'b0}}, cfg_i.gate_window};

  assign prim_ext = {{PIDX_W{1'b0}}, prim_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_is_last) begin
          state_nxt = ST_WALK1;
        end
      end
      ST_WALK1: begin
        if (walk_end) begin
          state_nxt = (m_found_r || s_found_r) ? ST_WALK2 : ST_DONE;
        end
      end
      ST_WALK2: begin
        if (walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    in_ready  = (state_r == ST_LOAD);
    ram_we    = (state_r == ST_LOAD) && in_valid && store_ok;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = {in_trig_type, in_trig_time};
    ram_raddr = rd_idx_r[AW-1:0];
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_primary_index = out_pidx_r;
  assign out_primary_time  = out_time_r;
  assign out_type_bits     = out_bits_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      pv_r        <= 1'b0;
      m_found_r   <= 1'b0;
      s_found_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      // A new result replaces the one taken in the same cycle.
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc && store_ok) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_WALK1: begin
          if (pv_r && main_hit) begin
            m_found_r <= 1'b1;
          end
          if (pv_r && sl_hit) begin
            s_found_r <= 1'b1;
          end
          if (walk_end) begin
            rd_idx_r <= '0;
          end
        end
        ST_WALK2: ;
        ST_DONE: begin
          if (out_free) begin
            cnt_r       <= '0;
            rd_idx_r    <= '0;
            m_found_r   <= 1'b0;
            s_found_r   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Selection datapath.
  always_ff @(posedge clk) begin
    pidx_r <= rd_idx_r[AW-1:0];
    case (state_r)
      ST_WALK1: begin
        // Earliest main-class time; ties go to the later entry.
        if (pv_r && main_hit && (!m_found_r || (rd_time <= t0_r))) begin
          prim_r  <= pidx_r;
          t0_r    <= rd_time;
          ptype_r <= rd_type;
        end
        if (pv_r && sl_hit && !s_found_r) begin
          s_idx_r  <= pidx_r;
          s_time_r <= rd_time;
          s_type_r <= rd_type;
        end
        // Fall back to the super-low candidate and seed the type bits.
        if (walk_end) begin
          if (!m_found_r) begin
            prim_r  <= s_idx_r;
            t0_r    <= s_time_r;
            ptype_r <= s_type_r;
            bits_r  <= type_bit(s_type_r);
          end else begin
            bits_r  <= type_bit(ptype_r);
          end
        end
      end
      ST_WALK2: begin
        if (pv_r && (((main_hit || sl_hit) && near_ok) ||
                     ((pidx_r != prim_r) && gate_ok))) begin
          bits_r <= bits_r | type_bit(rd_type);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_found_r <= m_found_r || s_found_r;
          if (m_found_r || s_found_r) begin
            out_pidx_r <= prim_ext[PIDX_W-1:0];
            out_time_r <= t0_r;
            out_bits_r <= bits_r;
          end else begin
            out_pidx_r <= '0;
            out_time_r <= '0;
            out_bits_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/primary_trigger_selector.sv
`default_nettype none

// Primary trigger selector. Candidates (type code, time count) are taken one
// per cycle while the block is loading, into a candidate memory of
// MAX_CANDIDATES entries; the request with in_is_last set closes the list.
// The block then walks the stored list through the memory's single read
// port: the first walk finds the earliest enabled main-class candidate (or
// the first enabled super-low one), and when one was found a second walk
// gathers the type bits within the near and gate windows. Each list gives
// one result request. While the walks run, in_ready is low, so the next
// list is not taken before they end; a finished result waits in the
// output register while the next list is loaded. Candidates beyond
// MAX_CANDIDATES are dropped, but a last flag on one still closes the list.
// Configuration is to be written by the user through the cfg_ port only
// while the block is idle; the block itself does not enforce this.
module primary_trigger_selector import ptsel_pkg::*; #(
  parameter int MAX_CANDIDATES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [TYPE_W-1:0]     in_trig_type,
  input  wire logic [TIME_W-1:0]     in_trig_time,
  input  wire logic                  in_is_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_found,
  output logic [PIDX_W-1:0]          out_primary_index,
  output logic [TIME_W-1:0]          out_primary_time,
  output logic [BITS_W-1:0]          out_type_bits
);

  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int DW = TYPE_W + TIME_W;

  ptsel_cfg_t      cfg;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  // Configuration registers.
  ptsel_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Candidate memory holding type and time of each entry.
  ptsel_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_CANDIDATES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load and selection sequencer.
  ptsel_engine #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_i             (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_trig_type      (in_trig_type),
    .in_trig_time      (in_trig_time),
    .in_is_last        (in_is_last),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_primary_index (out_primary_index),
    .out_primary_time  (out_primary_time),
    .out_type_bits     (out_type_bits)
  );

endmodule

`default_nettype wire

FILE: rtl/ptsel_checker.sv
`default_nettype none

`include "primary_trigger_selector_macros.svh"

module ptsel_checker import ptsel_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_found,
  input wire logic [PIDX_W-1:0] out_primary_index,
  input wire logic [TIME_W-1:0] out_primary_time,
  input wire logic [BITS_W-1:0] out_type_bits
);

  // A stalled result stays put.
  `PTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_primary_index) && $stable(out_primary_time) && $stable(out_type_bits))

  // A selected primary always contributes its own type bit.
  `PTS_ASSERT_IMP(a_found_bits, out_valid && out_found, out_type_bits != '0)

  // An empty selection reports all fields as zero.
  `PTS_ASSERT_IMP(a_none_zero, out_valid && !out_found, (out_primary_index == '0) && (out_primary_time == '0) && (out_type_bits == '0))

  // A new result never appears right after a candidate was taken.
  `PTS_ASSERT_IMP(a_result_gap, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind primary_trigger_selector ptsel_checker u_checker (.*);

`default_nettype wire
